// File: rtl/core/haversine_distance_macros.svh
// Assertion macros shared by the haversine distance RTL.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HVD_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("haversine_distance: assertion failed");

// Next-cycle implication, disabled in reset.
`define HVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("haversine_distance: assertion failed");

`endif

// File: rtl/core/hvd_pkg.sv
// Shared constants and tables for the haversine distance pipeline.
package hvd_pkg;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 40;
	localparam int LAT_W       = 24;
	localparam int LON_W       = 25;
	localparam int DIST_W      = 35;
	localparam int ANG_W       = 33;

	// pi * 2^32, split for two narrow partial products
	localparam logic [33:0] PI_Q32 = 34'h3243F6A89;
	localparam logic [16:0] PI_HI  = PI_Q32[33:17];
	localparam logic [16:0] PI_LO  = PI_Q32[16:0];
	// half of 180 * 2^18
	localparam logic [24:0] DEG_HALF = 25'd23592960;
	// ceil(2^45 / 45): exact floor division by 45 for values below 2^39
	localparam logic [39:0] DIV45_M  = 40'(((64'd1 << 45) + 64'd44) / 64'd45);
	localparam logic [19:0] DIV45_HI = DIV45_M[39:20];
	localparam logic [19:0] DIV45_LO = DIV45_M[19:0];

	localparam logic [30:0] HALFPI      = 31'd1686629713;
	localparam logic [29:0] HALFPI_HALF = 30'(HALFPI >> 1);
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [29:0] HALF_Q30    = 30'h2000_0000;

	localparam logic [32:0] RADIUS_MM = 33'd6370997000;
	localparam logic [16:0] RAD_HI    = RADIUS_MM[32:16];
	localparam logic [15:0] RAD_LO    = RADIUS_MM[15:0];
	localparam logic [34:0] DIST_MAX  = 35'd20015087000;

	// Taylor term divisors; M = ceil(2^S / N) gives an exact floor for inputs below 2^31
	localparam int unsigned SIN_N [6] = '{6, 20, 42, 72, 110, 156};
	localparam int unsigned SIN_S [6] = '{34, 36, 37, 38, 38, 39};
	localparam logic [31:0] SIN_M [6] = '{
		32'(((64'd1 << 34) + 64'd5) / 64'd6),
		32'(((64'd1 << 36) + 64'd19) / 64'd20),
		32'(((64'd1 << 37) + 64'd41) / 64'd42),
		32'(((64'd1 << 38) + 64'd71) / 64'd72),
		32'(((64'd1 << 38) + 64'd109) / 64'd110),
		32'(((64'd1 << 39) + 64'd155) / 64'd156)
	};
	localparam int unsigned COS_N [7] = '{2, 12, 30, 56, 90, 132, 182};
	localparam int unsigned COS_S [7] = '{32, 35, 36, 37, 38, 39, 39};
	localparam logic [31:0] COS_M [7] = '{
		32'(((64'd1 << 32) + 64'd1) / 64'd2),
		32'(((64'd1 << 35) + 64'd11) / 64'd12),
		32'(((64'd1 << 36) + 64'd29) / 64'd30),
		32'(((64'd1 << 37) + 64'd55) / 64'd56),
		32'(((64'd1 << 38) + 64'd89) / 64'd90),
		32'(((64'd1 << 39) + 64'd131) / 64'd132),
		32'(((64'd1 << 39) + 64'd181) / 64'd182)
	};
	localparam int POLY_ROUNDS = 7;

	localparam int FRONT_LAT     = 5;
	localparam int TRIG_LAT      = 2 + 2 * POLY_ROUNDS + 1;
	localparam int HAV_LAT       = 4;
	localparam int SAR_BITS      = 31;
	localparam int SAR_STEP_LAT  = TRIG_LAT + 2;
	localparam int OUT_LAT       = 2;
	localparam int PIPE_LAT      = FRONT_LAT + TRIG_LAT + HAV_LAT + SAR_BITS * SAR_STEP_LAT
		+ OUT_LAT;

	typedef enum logic [1:0] {
		QUAD_SIN     = 2'd0,
		QUAD_COS     = 2'd1,
		QUAD_NEG_SIN = 2'd2,
		QUAD_NEG_COS = 2'd3
	} quad_t;

endpackage

// File: rtl/core/hvd_trig.sv
// Pipelined fixed-point sine/cosine of a non-negative Q30 angle.
module hvd_trig (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hvd_pkg::ANG_W-1:0]   angle,
	input  logic                        want_cos,
	output logic signed [31:0]          value
);
	import hvd_pkg::*;

	typedef struct packed {
		logic [29:0] u2;
		quad_t       quad;
		logic        rneg;
	} trig_ctl_t;

	// quadrant reduction
	logic [33:0] biased;
	logic [2:0]  q;
	logic [34:0] r;

	always_comb begin
		biased = {1'b0, angle} + 34'(HALFPI_HALF);
		q = '0;
		for (int k = 1; k < 8; k++) begin
			if (biased >= 34'(k) * 34'(HALFPI))
				q = 3'(k);
		end
		r = {2'b0, angle} - 35'(q) * 35'(HALFPI);
	end

	logic [29:0] u_s1;
	logic        rneg_s1;
	quad_t       quad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= r[34] ? 30'(-r) : 30'(r);
			rneg_s1 <= r[34];
			quad_s1 <= quad_t'(2'(q) + 2'(want_cos));
		end
	end

	trig_ctl_t          ctl_r    [POLY_ROUNDS+1];
	logic [30:0]        sin_term [POLY_ROUNDS];
	logic [30:0]        cos_term [POLY_ROUNDS];
	logic signed [31:0] sin_sum  [POLY_ROUNDS+1];
	logic signed [31:0] cos_sum  [POLY_ROUNDS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_r[0].u2   <= 30'((61'(u_s1) * 61'(u_s1) + 61'(HALF_Q30)) >> 30);
			ctl_r[0].quad <= quad_s1;
			ctl_r[0].rneg <= rneg_s1;
			sin_term[0]   <= 31'(u_s1);
			cos_term[0]   <= ONE_Q30;
			sin_sum[0]    <= 32'(u_s1);
			cos_sum[0]    <= 32'(ONE_Q30);
		end
	end

	for (genvar k = 0; k < POLY_ROUNDS; k++) begin : g_round
		trig_ctl_t          ctl_a;
		logic signed [31:0] sin_sum_a;
		logic signed [31:0] cos_sum_a;
		logic [30:0]        cos_p_a;
		logic [31:0]        cos_w;
		logic [63:0]        cos_pr;
		logic [30:0]        cos_t;

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_a     <= ctl_r[k];
				sin_sum_a <= sin_sum[k];
				cos_sum_a <= cos_sum[k];
				cos_p_a   <= 31'((62'(cos_term[k]) * 62'(ctl_r[k].u2) + 62'(HALF_Q30)) >> 30);
			end
		end

		always_comb begin
			cos_w  = 32'(cos_p_a) + 32'(COS_N[k] / 2);
			cos_pr = 64'(cos_w) * 64'(COS_M[k]);
			cos_t  = 31'(cos_pr >> COS_S[k]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_r[k+1] <= ctl_a;
				if (k % 2 == 0)
					cos_sum[k+1] <= cos_sum_a - $signed({1'b0, cos_t});
				else
					cos_sum[k+1] <= cos_sum_a + $signed({1'b0, cos_t});
			end
		end

		if (k < POLY_ROUNDS - 1) begin : g_more
			logic [30:0] sin_p_a;
			logic [31:0] sin_w;
			logic [63:0] sin_pr;
			logic [30:0] sin_t;

			always_ff @(posedge clk) begin
				if (en)
					sin_p_a <= 31'((62'(sin_term[k]) * 62'(ctl_r[k].u2) + 62'(HALF_Q30)) >> 30);
			end

			always_comb begin
				sin_w  = 32'(sin_p_a) + 32'(SIN_N[k] / 2);
				sin_pr = 64'(sin_w) * 64'(SIN_M[k]);
				sin_t  = 31'(sin_pr >> SIN_S[k]);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					cos_term[k+1] <= cos_t;
					sin_term[k+1] <= sin_t;
					if (k % 2 == 0)
						sin_sum[k+1] <= sin_sum_a - $signed({1'b0, sin_t});
					else
						sin_sum[k+1] <= sin_sum_a + $signed({1'b0, sin_t});
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en)
					sin_sum[k+1] <= sin_sum_a;
			end
		end
	end

	logic signed [31:0] sin_v;
	assign sin_v = ctl_r[POLY_ROUNDS].rneg ? -sin_sum[POLY_ROUNDS] : sin_sum[POLY_ROUNDS];

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (ctl_r[POLY_ROUNDS].quad)
				QUAD_SIN:     value <= sin_v;
				QUAD_COS:     value <= cos_sum[POLY_ROUNDS];
				QUAD_NEG_SIN: value <= -sin_v;
				QUAD_NEG_COS: value <= -cos_sum[POLY_ROUNDS];
				default:      value <= sin_v;
			endcase
		end
	end

endmodule

// File: rtl/core/haversine_distance.sv
// Great-circle distance between two points, haversine formula, fully pipelined.
// Accepts one point pair per cycle while m_tready does not stall it, and returns one
// distance per pair, in order, through degree-to-radian conversion, the sine/cosine
// pipelines, the haversine term, the 31-step arcsine search (each step runs a 17-stage
// sine pipeline plus square and compare) and the radius scaling. The whole pipeline
// advances together; when m_tready is low with a result waiting, every stage holds and
// s_tready drops in the same cycle, so nothing is lost or repeated.
`include "haversine_distance_macros.svh"

module haversine_distance (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
	input  logic [hvd_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// distance_mm[34:0], zero pad
	output logic [hvd_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import hvd_pkg::*;

	localparam int SAR_END = FRONT_LAT + TRIG_LAT + HAV_LAT + SAR_BITS * SAR_STEP_LAT - 1;
	localparam int TGT_IDX = FRONT_LAT + TRIG_LAT + HAV_LAT - 1;

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	assign en       = !vld_q[PIPE_LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
	end

	// coordinates: lat_a, lon_a, lat_b, lon_b
	logic signed [LON_W-1:0] coord [4];
	logic [LON_W-1:0]        cmag  [4];

	always_comb begin
		coord[0] = LON_W'($signed(s_tdata[LAT_W-1:0]));
		coord[1] = $signed(s_tdata[48:24]);
		coord[2] = LON_W'($signed(s_tdata[72:49]));
		coord[3] = $signed(s_tdata[97:73]);
		for (int i = 0; i < 4; i++)
			cmag[i] = coord[i][LON_W-1] ? LON_W'(-coord[i]) : LON_W'(coord[i]);
	end

	logic [41:0]        pph_s1 [4];
	logic [41:0]        ppl_s1 [4];
	logic               neg_s1 [4];
	logic [38:0]        y_s2   [4];
	logic               neg_s2 [4];
	logic [58:0]        qh_s3  [4];
	logic [58:0]        ql_s3  [4];
	logic               neg_s3 [4];
	logic signed [33:0] rad_s4 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				pph_s1[i] <= 42'(cmag[i]) * 42'(PI_HI);
				ppl_s1[i] <= 42'(cmag[i]) * 42'(PI_LO);
				neg_s1[i] <= coord[i][LON_W-1];
				y_s2[i]   <= 39'(((60'(pph_s1[i]) << 17) + 60'(ppl_s1[i]) + 60'(DEG_HALF)) >> 20);
				neg_s2[i] <= neg_s1[i];
				qh_s3[i]  <= 59'(y_s2[i]) * 59'(DIV45_HI);
				ql_s3[i]  <= 59'(y_s2[i]) * 59'(DIV45_LO);
				neg_s3[i] <= neg_s2[i];
				rad_s4[i] <= neg_s3[i]
					? -$signed({1'b0, 33'(((80'(qh_s3[i]) << 20) + 80'(ql_s3[i])) >> 45)})
					: $signed({1'b0, 33'(((80'(qh_s3[i]) << 20) + 80'(ql_s3[i])) >> 45)});
			end
		end
	end

	logic signed [34:0] dlat, dlon;
	logic [34:0]        dlat_m, dlon_m;
	logic [ANG_W-1:0]   hlat_s5, hlon_s5, mla_s5, mlb_s5;

	always_comb begin
		dlat   = 35'(rad_s4[2]) - 35'(rad_s4[0]);
		dlon   = 35'(rad_s4[3]) - 35'(rad_s4[1]);
		dlat_m = dlat[34] ? 35'(-dlat) : 35'(dlat);
		dlon_m = dlon[34] ? 35'(-dlon) : 35'(dlon);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hlat_s5 <= ANG_W'(dlat_m >> 1);
			hlon_s5 <= ANG_W'(dlon_m >> 1);
			mla_s5  <= rad_s4[0][33] ? ANG_W'(-rad_s4[0]) : ANG_W'(rad_s4[0]);
			mlb_s5  <= rad_s4[2][33] ? ANG_W'(-rad_s4[2]) : ANG_W'(rad_s4[2]);
		end
	end

	logic signed [31:0] sin_lat, sin_lon, cos_a, cos_b;

	hvd_trig u_sin_lat (.clk, .en, .angle(hlat_s5), .want_cos(1'b0), .value(sin_lat));
	hvd_trig u_sin_lon (.clk, .en, .angle(hlon_s5), .want_cos(1'b0), .value(sin_lon));
	hvd_trig u_cos_a   (.clk, .en, .angle(mla_s5),  .want_cos(1'b1), .value(cos_a));
	hvd_trig u_cos_b   (.clk, .en, .angle(mlb_s5),  .want_cos(1'b1), .value(cos_b));

	logic [30:0] msl, mso, mca, mcb;

	always_comb begin
		msl = sin_lat[31] ? 31'(-sin_lat) : 31'(sin_lat);
		mso = sin_lon[31] ? 31'(-sin_lon) : 31'(sin_lon);
		mca = cos_a[31] ? 31'(-cos_a) : 31'(cos_a);
		mcb = cos_b[31] ? 31'(-cos_b) : 31'(cos_b);
	end

	logic [61:0] sqlat_s23, sqlon_s23, ccp_s23;
	logic        ccneg_s23;
	logic [30:0] slat_s24, slon_s24, ccm_s24;
	logic        ccneg_s24;
	logic [61:0] p2_s25;
	logic [30:0] slat_s25;
	logic        neg_s25;
	logic [30:0] tgt_s26;

	logic [30:0]        p2r;
	logic signed [32:0] a_sum;

	always_comb begin
		p2r   = 31'((63'(p2_s25) + 63'(HALF_Q30)) >> 30);
		a_sum = $signed({2'b0, slat_s25})
			+ (neg_s25 ? -$signed({2'b0, p2r}) : $signed({2'b0, p2r}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqlat_s23 <= 62'(msl) * 62'(msl);
			sqlon_s23 <= 62'(mso) * 62'(mso);
			ccp_s23   <= 62'(mca) * 62'(mcb);
			ccneg_s23 <= cos_a[31] ^ cos_b[31];
			slat_s24  <= 31'((63'(sqlat_s23) + 63'(HALF_Q30)) >> 30);
			slon_s24  <= 31'((63'(sqlon_s23) + 63'(HALF_Q30)) >> 30);
			ccm_s24   <= 31'((63'(ccp_s23) + 63'(HALF_Q30)) >> 30);
			ccneg_s24 <= ccneg_s23;
			p2_s25    <= 62'(ccm_s24) * 62'(slon_s24);
			slat_s25  <= slat_s24;
			neg_s25   <= ccneg_s24;
			if (a_sum[32])
				tgt_s26 <= '0;
			else if (a_sum > $signed({2'b0, ONE_Q30}))
				tgt_s26 <= ONE_Q30;
			else
				tgt_s26 <= a_sum[30:0];
		end
	end

	// arcsine by successive approximation, most significant bit first
	logic [30:0] sar_theta [SAR_BITS];
	logic [30:0] sar_tgt   [SAR_BITS-1];

	for (genvar j = 0; j < SAR_BITS; j++) begin : g_sar
		localparam logic [30:0] TRY_BIT = 31'(1) << (SAR_BITS - 1 - j);

		logic [30:0]        th_in, tg_in;
		logic signed [31:0] s_val;
		logic [30:0]        s_mag;
		logic [30:0]        th_s [TRIG_LAT+1];
		logic [30:0]        tg_s [TRIG_LAT+1];
		logic [61:0]        sq_s18;
		logic [30:0]        t_try;
		logic               keep;

		if (j == 0) begin : g_first
			assign th_in = '0;
			assign tg_in = tgt_s26;
		end else begin : g_next
			assign th_in = sar_theta[j-1];
			assign tg_in = sar_tgt[j-1];
		end

		hvd_trig u_sin (
			.clk,
			.en,
			.angle(ANG_W'(th_in | TRY_BIT)),
			.want_cos(1'b0),
			.value(s_val)
		);

		assign s_mag = s_val[31] ? 31'(-s_val) : 31'(s_val);
		assign t_try = th_s[TRIG_LAT] | TRY_BIT;
		assign keep  = (t_try <= HALFPI) && (sq_s18 <= (62'(tg_s[TRIG_LAT]) << 30));

		always_ff @(posedge clk) begin
			if (en) begin
				th_s[0] <= th_in;
				tg_s[0] <= tg_in;
				for (int i = 1; i <= TRIG_LAT; i++) begin
					th_s[i] <= th_s[i-1];
					tg_s[i] <= tg_s[i-1];
				end
				sq_s18       <= 62'(s_mag) * 62'(s_mag);
				sar_theta[j] <= keep ? t_try : th_s[TRIG_LAT];
			end
		end

		if (j < SAR_BITS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en)
					sar_tgt[j] <= tg_s[TRIG_LAT];
			end
		end
	end

	logic [47:0]       rph_s1;
	logic [46:0]       rpl_s1;
	logic [DIST_W-1:0] dist_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rph_s1 <= 48'(sar_theta[SAR_BITS-1]) * 48'(RAD_HI);
			rpl_s1 <= 47'(sar_theta[SAR_BITS-1]) * 47'(RAD_LO);
			dist_q <= DIST_W'(((64'(rph_s1) << 16) + 64'(rpl_s1) + (64'd1 << 28)) >> 29);
		end
	end

	assign m_tdata = {(OUT_TDATA_W - DIST_W)'(0), dist_q};

	`HVD_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, vld_q[0])
	`HVD_ASSERT(a_target_clamped, clk, arst_n, vld_q[TGT_IDX], tgt_s26 <= ONE_Q30)
	`HVD_ASSERT(a_theta_range, clk, arst_n, vld_q[SAR_END], sar_theta[SAR_BITS-1] <= HALFPI)
	`HVD_ASSERT(a_dist_range, clk, arst_n, m_tvalid, dist_q <= DIST_MAX)

endmodule
